/* sv/packet_fifo_dedup_range_count_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the packet buffer
// Shared concurrent-assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PACKET_FIFO_DEDUP_RANGE_COUNT_MACROS_SVH
`define PACKET_FIFO_DEDUP_RANGE_COUNT_MACROS_SVH

// Same-cycle implication.
`define PFDRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfdrc assertion failed");

// Next-cycle implication.
`define PFDRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfdrc assertion failed");

`endif

/* sv/pfdrc_pkg.sv */
// ----------------------------------------------------------------------------
// pfdrc_pkg
// Types and constants shared by the packet buffer cells and top level.
// ----------------------------------------------------------------------------
package pfdrc_pkg;

    localparam int PFDRC_CAPACITY = 64;

    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 7;
    localparam int CNT_W   = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_FWD   = 2'd1;
    localparam logic [1:0] MODE_COUNT = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   src;
        logic [ID_W-1:0]   dst;
        logic [TIME_W-1:0] stamp;
    } t_pkt;

    typedef struct packed {
        logic shift;   // take neighbor's packet
        logic load;    // take the new packet (wins over shift)
    } t_cell_ctl;

endpackage

/* sv/packet_fifo_dedup_range_count.sv */
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count
// FIFO packet buffer with duplicate filter and destination/time range count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request item: mode,
//   source, destination, timestamp and a time window. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result item per request.
//   i_cfg_wr_en / i_cfg_wr_data write memory_limit (0 acts as 1, values above
//   CAPACITY act as CAPACITY); write it only while the block is idle.
// Sequence per item (item in to result out):
//   add      : ring scan, then the write step (ST_WRITE), then the result is
//              loaded into the output register; the next item is taken after it
//   count    : ring scan, then the result; the next item is taken after it
//   forward  : no scan, the result goes out directly; unused mode the same
//   One item is in flight at a time; the scan of the cell ring sets the
//   rate, one stored packet compared per cycle at cell 0.
// Reset (i_rst_n low, synchronous): buffer empty, limit = 64, no result
//   pending. Stored packet data is not cleared.
// Receiver stall: the result sits in the output register; the next item is
//   still taken and worked on, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`include "packet_fifo_dedup_range_count_macros.svh"

module packet_fifo_dedup_range_count import pfdrc_pkg::*; #(
    parameter int CAPACITY = PFDRC_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [ID_W-1:0]    i_source_id,
    input  logic [ID_W-1:0]    i_dest_id,
    input  logic [TIME_W-1:0]  i_time_stamp,
    input  logic [TIME_W-1:0]  i_start_time,
    input  logic [TIME_W-1:0]  i_end_time,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_accepted,
    output logic               o_fwd_valid,
    output logic [ID_W-1:0]    o_fwd_source,
    output logic [ID_W-1:0]    o_fwd_dest,
    output logic [TIME_W-1:0]  o_fwd_time,
    output logic [CNT_W-1:0]   o_range_count
);

    // fill level / scan step width: holds 0..CAPACITY
    localparam int FW = $clog2(CAPACITY + 1);
    // width for the limit compare
    localparam int LW = (FW > LIMIT_W) ? FW : LIMIT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    // control state
    logic [1:0]         r_state;
    logic [FW-1:0]      r_fill;
    logic [FW-1:0]      r_step;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid;
    logic               r_dup;
    logic [CNT_W-1:0]   r_cnt;

    // request / pending result / output payload
    logic [1:0]         r_mode;
    t_pkt               r_req;
    logic [TIME_W-1:0]  r_lo;
    logic [TIME_W-1:0]  r_hi;
    logic               r_p_acc;
    logic               r_p_fv;
    t_pkt               r_p_pkt;
    logic               r_o_acc;
    logic               r_o_fv;
    t_pkt               r_o_pkt;
    logic [CNT_W-1:0]   r_o_cnt;

    t_pkt               w_cell [CAPACITY];
    t_pkt               w_head;
    t_pkt               w_in_pkt;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_live;
    logic               w_last;
    logic               w_hit_dup;
    logic               w_hit_cnt;
    logic               w_evict;
    logic               w_rot;
    logic               w_wr;
    logic [FW-1:0]      w_widx;
    logic [LW-1:0]      w_lim_ext;
    logic [LW-1:0]      w_cap_ext;
    logic [LW-1:0]      w_eff;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_in_pkt.src   = i_source_id;
    assign w_in_pkt.dst   = i_dest_id;
    assign w_in_pkt.stamp = i_time_stamp;

    // cell 0 always holds the oldest entry when idle; during a scan it
    // holds entry r_step as the ring turns
    assign w_head = w_cell[0];
    assign w_live = (r_step < r_fill);
    assign w_last = (r_step == FW'(CAPACITY - 1));

    assign w_hit_dup = (w_head.src == r_req.src) && (w_head.dst == r_req.dst)
                    && (w_head.stamp == r_req.stamp);
    assign w_hit_cnt = (w_head.dst == r_req.dst) && (w_head.stamp >= r_lo)
                    && (w_head.stamp <= r_hi);

    // effective limit: clamp into 1..CAPACITY
    assign w_lim_ext = LW'(r_limit);
    assign w_cap_ext = LW'(CAPACITY);
    always_comb begin
        if (r_limit == '0) begin
            w_eff = LW'(1);
        end else if (w_lim_ext > w_cap_ext) begin
            w_eff = w_cap_ext;
        end else begin
            w_eff = w_lim_ext;
        end
    end

    // a full buffer (at limit) drops the oldest on a successful add
    assign w_evict = (LW'(r_fill) >= w_eff) && (r_fill != '0);
    assign w_wr    = (r_state == ST_WRITE) && !r_dup;
    assign w_widx  = w_evict ? (r_fill - FW'(1)) : r_fill;

    // ring rotates for scan, for a pop, and for the eviction on add
    assign w_rot = (r_state == ST_SCAN)
                || (w_in_acc && (i_mode == MODE_FWD) && (r_fill != '0))
                || (w_wr && w_evict);

    // ------------------------------------------------------------------
    // cell ring: cell i takes cell i+1, the last cell wraps to cell 0
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.shift = w_rot;
        assign w_ctl.load  = w_wr && (w_widx == FW'(gi));

        pfdrc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_load_pkt (r_req),
            .i_next_pkt (w_cell[(gi + 1) % CAPACITY]),
            .o_pkt      (w_cell[gi])
        );
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_step      <= '0;
            r_limit     <= LIMIT_RST;
            r_out_valid <= 1'b0;
            r_dup       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            // in HOLD the output register is reloaded below instead
            if (r_out_valid && !i_out_stall && r_state != ST_HOLD) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_step <= '0;
                        r_dup  <= 1'b0;
                        r_cnt  <= '0;
                        if (i_mode == MODE_ADD || i_mode == MODE_COUNT) begin
                            r_state <= ST_SCAN;
                        end else begin
                            if (i_mode == MODE_FWD && r_fill != '0) begin
                                r_fill <= r_fill - FW'(1);
                            end
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_live) begin
                        if (w_hit_dup) begin
                            r_dup <= 1'b1;
                        end
                        if (w_hit_cnt && r_cnt != '1) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                    r_step <= r_step + FW'(1);
                    if (w_last) begin
                        r_state <= (r_mode == MODE_ADD) ? ST_WRITE : ST_HOLD;
                    end
                end
                ST_WRITE: begin
                    if (!r_dup && !w_evict) begin
                        r_fill <= r_fill + FW'(1);
                    end
                    r_state <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request capture, pending result, output register (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode  <= i_mode;
            r_req   <= w_in_pkt;
            r_lo    <= i_start_time;
            r_hi    <= i_end_time;
            r_p_acc <= 1'b0;
            // a forward on a non-empty buffer returns the oldest packet
            r_p_fv  <= (i_mode == MODE_FWD) && (r_fill != '0);
            r_p_pkt <= ((i_mode == MODE_FWD) && (r_fill != '0)) ? w_head : '0;
        end
        if (w_wr) begin
            r_p_acc <= 1'b1;
        end
        if (r_state == ST_HOLD && w_out_free) begin
            r_o_acc <= r_p_acc;
            r_o_fv  <= r_p_fv;
            r_o_pkt <= r_p_pkt;
            r_o_cnt <= (r_mode == MODE_COUNT) ? r_cnt : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_o_acc;
    assign o_fwd_valid   = r_o_fv;
    assign o_fwd_source  = r_o_pkt.src;
    assign o_fwd_dest    = r_o_pkt.dst;
    assign o_fwd_time    = r_o_pkt.stamp;
    assign o_range_count = r_o_cnt;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `PFDRC_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(CAPACITY))
    `PFDRC_ASSERT_NOW(a_step_bound, i_clk, i_rst_n, r_state == ST_SCAN,
        r_step < FW'(CAPACITY))
    `PFDRC_ASSERT_NEXT(a_add_scans, i_clk, i_rst_n, w_in_acc && i_mode == MODE_ADD,
        r_state == ST_SCAN && r_step == '0)
    `PFDRC_ASSERT_NEXT(a_pop_fill, i_clk, i_rst_n,
        w_in_acc && i_mode == MODE_FWD && r_fill != '0,
        r_fill == FW'($past(r_fill) - FW'(1)))

endmodule

/* sv/pfdrc_cell.sv */
// ----------------------------------------------------------------------------
// pfdrc_cell
// One storage cell of the packet ring: holds one packet, shifts or loads.
// ----------------------------------------------------------------------------
module pfdrc_cell import pfdrc_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_pkt      i_load_pkt,
    input  t_pkt      i_next_pkt,
    output t_pkt      o_pkt
);

    t_pkt r_pkt;
    t_pkt n_pkt;

    always_comb begin
        if (i_ctl.load) begin
            n_pkt = i_load_pkt;
        end else if (i_ctl.shift) begin
            n_pkt = i_next_pkt;
        end else begin
            n_pkt = r_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
    end

    assign o_pkt = r_pkt;

endmodule

/* bench/pfdrc_result_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdrc_result_check
// Watches the request, result and limit-write ports of the packet buffer.
// Keeps its own copy of the held packets and the limit, works out the result
// of every accepted request item and compares each returned item with it.
// ----------------------------------------------------------------------------
module pfdrc_result_check import pfdrc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [ID_W-1:0]    i_source_id,
    input  logic [ID_W-1:0]    i_dest_id,
    input  logic [TIME_W-1:0]  i_time_stamp,
    input  logic [TIME_W-1:0]  i_start_time,
    input  logic [TIME_W-1:0]  i_end_time,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_accepted,
    input  logic               i_fwd_valid,
    input  logic [ID_W-1:0]    i_fwd_source,
    input  logic [ID_W-1:0]    i_fwd_dest,
    input  logic [TIME_W-1:0]  i_fwd_time,
    input  logic [CNT_W-1:0]   i_range_count,
    output int                 o_n_pending,
    output int                 o_n_fail
);

    typedef struct packed {
        logic              accepted;
        logic              fwd_valid;
        logic [ID_W-1:0]   fwd_source;
        logic [ID_W-1:0]   fwd_dest;
        logic [TIME_W-1:0] fwd_time;
        logic [CNT_W-1:0]  range_count;
    } t_reply;

    t_pkt               held_pkts[$];       // oldest first
    t_reply             pending_results[$];
    logic [LIMIT_W-1:0] limit_reg;          // loaded while reset is held
    int                 n_fail = 0;

    // 0 behaves as 1, anything above capacity as capacity
    function automatic int depth_limit();
        int lim;
        lim = int'(limit_reg);
        if (lim == 0) lim = 1;
        if (lim > PFDRC_CAPACITY) lim = PFDRC_CAPACITY;
        return lim;
    endfunction

    function automatic t_reply apply_request(input logic [1:0] mode, input t_pkt pkt,
                                             input logic [TIME_W-1:0] lo,
                                             input logic [TIME_W-1:0] hi);
        t_reply r;
        t_pkt   oldest;
        bit     dup;
        int     hits;
        r    = '0;
        dup  = 1'b0;
        hits = 0;
        case (mode)
            MODE_ADD: begin
                foreach (held_pkts[k])
                    if (held_pkts[k] == pkt) dup = 1'b1;
                if (!dup) begin
                    // one eviction at most, even if the limit was lowered
                    if (held_pkts.size() >= depth_limit() && held_pkts.size() > 0)
                        oldest = held_pkts.pop_front();
                    held_pkts.push_back(pkt);
                    r.accepted = 1'b1;
                end
            end
            MODE_FWD: begin
                if (held_pkts.size() > 0) begin
                    oldest       = held_pkts.pop_front();
                    r.fwd_valid  = 1'b1;
                    r.fwd_source = oldest.src;
                    r.fwd_dest   = oldest.dst;
                    r.fwd_time   = oldest.stamp;
                end
            end
            MODE_COUNT: begin
                foreach (held_pkts[k])
                    if (held_pkts[k].dst == pkt.dst && held_pkts[k].stamp >= lo &&
                        held_pkts[k].stamp <= hi)
                        hits++;
                if (hits > 127) hits = 127;
                r.range_count = hits[CNT_W-1:0];
            end
            default: ;  // unused mode: all zero, nothing changes
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        t_pkt   pkt;
        if (!i_rst_n) begin
            held_pkts.delete();
            pending_results.delete();
            limit_reg = LIMIT_RST;
        end else begin
            if (i_cfg_wr_en)
                limit_reg = i_cfg_wr_data;

            if (i_out_valid && !i_out_stall) begin
                got = {i_accepted, i_fwd_valid, i_fwd_source, i_fwd_dest, i_fwd_time,
                       i_range_count};
                if (pending_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: result item with none outstanding: acc=%0d fv=%0d "
                                 , $time, got.accepted, got.fwd_valid,
                                 "src=%h dst=%h ts=%h cnt=%0d", got.fwd_source,
                                 got.fwd_dest, got.fwd_time, got.range_count);
                end else begin
                    want = pending_results.pop_front();
                    if (got.accepted !== want.accepted || got.fwd_valid !== want.fwd_valid ||
                        got.fwd_source !== want.fwd_source ||
                        got.fwd_dest !== want.fwd_dest || got.fwd_time !== want.fwd_time ||
                        got.range_count !== want.range_count) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("%0t: mismatch", $time);
                            $display("  exp acc=%0d fv=%0d src=%h dst=%h ts=%h cnt=%0d",
                                     want.accepted, want.fwd_valid, want.fwd_source,
                                     want.fwd_dest, want.fwd_time, want.range_count);
                            $display("  got acc=%0d fv=%0d src=%h dst=%h ts=%h cnt=%0d",
                                     got.accepted, got.fwd_valid, got.fwd_source,
                                     got.fwd_dest, got.fwd_time, got.range_count);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                pkt = '{src: i_source_id, dst: i_dest_id, stamp: i_time_stamp};
                pending_results.push_back(apply_request(i_mode, pkt, i_start_time,
                                                        i_end_time));
            end
        end
        o_n_pending <= pending_results.size();
        o_n_fail    <= n_fail;
    end

endmodule

/* bench/tb_packet_fifo_dedup_range_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_fifo_dedup_range_count
// Drives add, forward, count and unused-mode request items into the packet
// buffer under a series of memory limits, with bursty input and a stalling
// receiver; the result checker beside the block scores every result item.
// ----------------------------------------------------------------------------
module tb_packet_fifo_dedup_range_count;
    import pfdrc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // The block scans at most CAPACITY entries per item, plus its setup and write
    // steps; SETTLE_CYCLES is the quiet wait given after its last result.
    localparam int SETTLE_CYCLES = PFDRC_CAPACITY + 8;
    localparam int LONG_HOLD     = 500;         // receiver back-pressure, in cycles
    localparam int TIMEOUT_NS    = 25_000_000;  // hard-stop time, in ns

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [1:0]         req_mode    = MODE_ADD;
    logic [ID_W-1:0]    req_source  = '0;
    logic [ID_W-1:0]    req_dest    = '0;
    logic [TIME_W-1:0]  req_stamp   = '0;
    logic [TIME_W-1:0]  req_start   = '0;
    logic [TIME_W-1:0]  req_end     = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic               res_accepted;
    logic               res_fwd_valid;
    logic [ID_W-1:0]    res_fwd_source;
    logic [ID_W-1:0]    res_fwd_dest;
    logic [TIME_W-1:0]  res_fwd_time;
    logic [CNT_W-1:0]   res_range_count;

    int n_pending;
    int n_fail;
    int hold_req = 0;       // bumped by the sender to ask for a long receiver hold
    int burst_left = 0;

    // Small value pools so that duplicates and count hits happen often.
    logic [ID_W-1:0]   id_pool[4];
    logic [TIME_W-1:0] stamp_pool[6];

    packet_fifo_dedup_range_count u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_mode        (req_mode),
        .i_source_id   (req_source),
        .i_dest_id     (req_dest),
        .i_time_stamp  (req_stamp),
        .i_start_time  (req_start),
        .i_end_time    (req_end),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_accepted    (res_accepted),
        .o_fwd_valid   (res_fwd_valid),
        .o_fwd_source  (res_fwd_source),
        .o_fwd_dest    (res_fwd_dest),
        .o_fwd_time    (res_fwd_time),
        .o_range_count (res_range_count)
    );

    pfdrc_result_check u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_mode        (req_mode),
        .i_source_id   (req_source),
        .i_dest_id     (req_dest),
        .i_time_stamp  (req_stamp),
        .i_start_time  (req_start),
        .i_end_time    (req_end),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_accepted    (res_accepted),
        .i_fwd_valid   (res_fwd_valid),
        .i_fwd_source  (res_fwd_source),
        .i_fwd_dest    (res_fwd_dest),
        .i_fwd_time    (res_fwd_time),
        .i_range_count (res_range_count),
        .o_n_pending   (n_pending),
        .o_n_fail      (n_fail)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("[packet_fifo_dedup_range_count] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stretches of random length, each with its own stall
    // style (none, light, heavy, toggling). When the sender asks for it,
    // stall hard for the LONG_HOLD span so the block backs up into its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        int holds_done;
        int style;
        int span;
        holds_done = 0;
        forever begin
            if (hold_req > holds_done) begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(10, 150);
                repeat (span) begin
                    case (style)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= ~out_stall;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    // Present one item and hold it until the block takes it. Between bursts
    // the valid may drop for a random gap; some gaps run past the block's scan time
    // so idle cycles land on every phase of its work.
    task automatic offer(input logic [1:0] mode, input t_pkt pkt,
                         input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
        int gap;
        in_valid   <= 1'b1;
        req_mode   <= mode;
        req_source <= pkt.src;
        req_dest   <= pkt.dst;
        req_stamp  <= pkt.stamp;
        req_start  <= lo;
        req_end    <= hi;
        do @(posedge clk); while (in_stall);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drain: stop offering, wait for every outstanding result, give the
    // block time to finish any scan, then write the limit register.
    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        in_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            8, 9:    return ID_W'($urandom);
            default: return id_pool[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_stamp();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return stamp_pool[$urandom_range(0, 5)];
    endfunction

    // One random item. Fields a mode does not use are filled with noise.
    task automatic offer_random(input int add_pct, input int fwd_pct);
        t_pkt              pkt;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] tmp;
        int                pick;
        pick = $urandom_range(0, 99);
        pkt  = '{src: ID_W'($urandom), dst: ID_W'($urandom), stamp: $urandom};
        lo   = $urandom;
        hi   = $urandom;
        if (pick < add_pct) begin
            pkt = '{src: pick_id(), dst: pick_id(), stamp: pick_stamp()};
            offer(MODE_ADD, pkt, lo, hi);
        end else if (pick < add_pct + fwd_pct) begin
            offer(MODE_FWD, pkt, lo, hi);
        end else if (pick < 97) begin
            pkt.dst = pick_id();
            lo      = pick_stamp();
            hi      = pick_stamp();
            case ($urandom_range(0, 4))
                0: begin                    // whole time axis
                    lo = '0;
                    hi = '1;
                end
                1: hi = lo;                 // single instant
                2: if (lo < hi) begin       // start after end
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                default: if (lo > hi) begin // ordered window
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            endcase
            offer(MODE_COUNT, pkt, lo, hi);
        end else begin
            offer(MODE_UNUSED, pkt, lo, hi);
        end
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_items,
                             input int add_pct, input int fwd_pct, input bit with_hold);
        write_limit(lim);
        for (int i = 0; i < n_items; i++) begin
            // ask for the long hold a little way in, while items keep coming
            if (with_hold && i == 20)
                hold_req <= hold_req + 1;
            offer_random(add_pct, fwd_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_pkt zero_pkt;
        t_pkt ones_pkt;
        zero_pkt = '0;
        ones_pkt = '1;
        id_pool    = '{16'h0000, 16'hFFFF, ID_W'($urandom), ID_W'($urandom)};
        stamp_pool = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                       32'h8000_0000, $urandom, 32'hFFFF_FFFF};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset limit.
        offer(MODE_FWD, zero_pkt, '0, '0);                      // forward on empty
        offer(MODE_UNUSED, zero_pkt, '0, '0);                   // unused mode
        offer(MODE_COUNT, zero_pkt, '0, '1);                    // count on empty
        offer(MODE_ADD, zero_pkt, '1, '1);                      // all-zero packet
        offer(MODE_ADD, ones_pkt, '0, '0);                      // all-ones packet
        offer(MODE_ADD, zero_pkt, '0, '0);                      // duplicate, refused
        offer(MODE_ADD, '{src: '0, dst: '0, stamp: 32'd1}, '0, '0);   // differs in time
        offer(MODE_ADD, '{src: 16'd1, dst: '0, stamp: '0}, '0, '0);   // differs in source
        offer(MODE_ADD, '{src: '0, dst: 16'd1, stamp: '0}, '0, '0);   // differs in dest
        offer(MODE_ADD, ones_pkt, '0, '0);                      // duplicate of all-ones
        offer(MODE_COUNT, zero_pkt, '0, '1);                    // full window
        offer(MODE_COUNT, zero_pkt, 32'd1, 32'd0);              // start after end
        offer(MODE_COUNT, ones_pkt, '1, '1);                    // top edge only
        offer(MODE_COUNT, zero_pkt, '0, '0);                    // bottom edge only
        offer(MODE_UNUSED, ones_pkt, '1, '1);                   // unused mode, all ones
        offer(MODE_FWD, ones_pkt, '1, '1);                      // pops the all-zero packet
        offer(MODE_ADD, zero_pkt, '0, '0);                      // no longer a duplicate
        for (int i = 0; i < 6; i++)
            offer(MODE_FWD, zero_pkt, '0, '0);                  // drain, last one on empty

        // Random part: several limits, extremes and out-of-range values
        // included. The 127 phase fills up to capacity, then the limit is
        // dropped to 5 with the buffer still full.
        run_phase(7'd64,  180, 60, 15, 1'b1);
        run_phase(7'd1,    90, 55, 20, 1'b0);
        run_phase(7'd0,    70, 55, 20, 1'b0);
        run_phase(7'd127, 170, 75, 5,  1'b0);
        run_phase(7'd5,   140, 35, 35, 1'b1);
        run_phase(7'd65,  100, 60, 15, 1'b0);
        run_phase(7'd16,  130, 40, 40, 1'b0);
        run_phase(7'd3,   120, 50, 25, 1'b0);

        // Wind down: everything answered, then a quiet wait to catch any
        // stray result item.
        in_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        if (n_fail == 0 && n_pending == 0)
            $display("[packet_fifo_dedup_range_count] OK");
        else
            $display("[packet_fifo_dedup_range_count] ERROR");
        $finish;
    end

endmodule
